[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_NEVER(lbl, expr)

`endif

`endif

[rtl/bst_pkg.sv]
// ----------------------------------------------------------------------------
// bst_pkg
// shared types and constants of the binary search table
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IN_TDATA_W = 88;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - 1 - IDX_W;

  // in_tuser codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RESULT
  } bst_state_t;

endpackage

[rtl/bst_ram.sv]
// ----------------------------------------------------------------------------
// bst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bst_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/binary_search_table.sv]
// ----------------------------------------------------------------------------
// binary_search_table
// write items: written in S_IDLE, no result
// search items: one table read per probe, P probes with P <= floor(log2(range))+1
// search path: S_IDLE, S_CHECK once per probe, then S_RESULT (an empty range skips S_CHECK)
// S_RESULT waits until the output register is free, then loads the result
// next item taken the cycle after the result is loaded; one probe per cycle
// rst_n clears control and output valid only; table contents undefined until written
`include "assert_macros.svh"

module binary_search_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // write_index, write_value, key, low_bound, high_bound
  input  logic [bst_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // found, position, zero padding
  output logic [bst_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [8:0] DEPTH_9 = 9'((TABLE_DEPTH >= 256) ? 256 : TABLE_DEPTH);

  function automatic logic [AW-1:0] wrap_idx(input logic [7:0] idx);
    logic [8:0] rem;
    rem = '0;
    if (TABLE_DEPTH >= 256) begin
      return AW'(idx);
    end
    for (int b = 7; b >= 0; b--) begin
      rem = {rem[7:0], idx[b]};
      if (rem >= DEPTH_9) begin
        rem = rem - DEPTH_9;
      end
    end
    return AW'(rem);
  endfunction

  // payload fields
  logic [7:0]  in_write_index;
  logic [31:0] in_write_value;
  logic [31:0] in_key;
  logic [7:0]  in_low_bound;
  logic [7:0]  in_high_bound;

  assign in_write_index = in_tdata[7:0];
  assign in_write_value = in_tdata[39:8];
  assign in_key         = in_tdata[71:40];
  assign in_low_bound   = in_tdata[79:72];
  assign in_high_bound  = in_tdata[87:80];

  logic [ENTRY_WIDTH-1:0] key_ext;
  logic [ENTRY_WIDTH-1:0] wval_ext;

  if (ENTRY_WIDTH <= 32) begin : g_narrow
    assign key_ext  = in_key[ENTRY_WIDTH-1:0];
    assign wval_ext = in_write_value[ENTRY_WIDTH-1:0];
  end else begin : g_wide
    assign key_ext  = {{(ENTRY_WIDTH-32){in_key[31]}}, in_key};
    assign wval_ext = {{(ENTRY_WIDTH-32){1'b0}}, in_write_value};
  end

  bst_pkg::bst_state_t state_r, state_nxt;
  logic [8:0]             lo_r, lo_nxt;
  logic [7:0]             hi_r, hi_nxt;
  logic [7:0]             mid_r, mid_nxt;
  logic [ENTRY_WIDTH-1:0] key_r, key_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [7:0]             res_pos_r, res_pos_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [7:0]             out_pos_r, out_pos_nxt;

  logic                   ram_we;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic [8:0]             cand_lo;
  logic [8:0]             cand_hi;
  logic                   probe;
  logic [9:0]             probe_sum;
  logic [7:0]             probe_mid;
  logic                   in_ready_int;

  assign probe_sum = {1'b0, cand_lo} + {1'b0, cand_hi};
  assign probe_mid = probe_sum[8:1];

  bst_ram #(
    .DATA_W (ENTRY_WIDTH),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wrap_idx(in_write_index)),
    .wr_data (wval_ext),
    .rd_addr (wrap_idx(probe_mid)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bst_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    res_found_nxt  = res_found_r;
    res_pos_nxt    = res_pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    in_ready_int   = 1'b0;
    ram_we         = 1'b0;
    cand_lo        = lo_r;
    cand_hi        = {1'b0, hi_r};
    probe          = 1'b0;

    case (state_r)
      bst_pkg::S_IDLE: begin
        in_ready_int = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == bst_pkg::ACT_WRITE) begin
            ram_we = 1'b1;
          end else begin
            key_nxt = key_ext;
            cand_lo = {1'b0, in_low_bound};
            cand_hi = {1'b0, in_high_bound};
            probe   = 1'b1;
          end
        end
      end
      bst_pkg::S_CHECK: begin
        if (key_r == rd_data) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = bst_pkg::S_RESULT;
        end else if ($signed(key_r) < $signed(rd_data)) begin
          if (mid_r == '0) begin
            // range would drop below index zero
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = bst_pkg::S_RESULT;
          end else begin
            cand_lo = lo_r;
            cand_hi = {1'b0, mid_r - 8'd1};
            probe   = 1'b1;
          end
        end else begin
          cand_lo = {1'b0, mid_r} + 9'd1;
          cand_hi = {1'b0, hi_r};
          probe   = 1'b1;
        end
      end
      bst_pkg::S_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = res_found_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = bst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bst_pkg::S_IDLE;
      end
    endcase

    if (probe) begin
      if (cand_lo > cand_hi) begin
        res_found_nxt = 1'b0;
        res_pos_nxt   = '0;
        state_nxt     = bst_pkg::S_RESULT;
      end else begin
        lo_nxt    = cand_lo;
        hi_nxt    = cand_hi[7:0];
        mid_nxt   = probe_mid;
        state_nxt = bst_pkg::S_CHECK;
      end
    end
  end

  assign in_tready  = in_ready_int;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{bst_pkg::OUT_PAD_W{1'b0}}, out_pos_r, out_found_r};

  `ASSERT_IMPLY(a_range_nonempty, state_r == bst_pkg::S_CHECK, lo_r <= {1'b0, hi_r})
  `ASSERT_IMPLY(a_mid_in_range, state_r == bst_pkg::S_CHECK,
    ({1'b0, mid_r} >= lo_r) && (mid_r <= hi_r))
  `ASSERT_NEXT(a_write_stays_idle,
    in_tvalid && in_tready && (in_tuser == bst_pkg::ACT_WRITE), state_r == bst_pkg::S_IDLE)
  `ASSERT_IMPLY(a_miss_pos_zero, out_tvalid_r && !out_found_r, out_pos_r == '0)

endmodule

[tb/binary_search_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_search_table_tb
// writes sorted and unsorted tables through the input stream and searches
// them; a tracker keeps its own copy of the table, walks each search and
// compares every result transfer with the oldest outstanding lookup
// ----------------------------------------------------------------------------

typedef struct packed {
  logic       found;
  logic [7:0] position;
} lookup_t;

class table_tracker;
  logic signed [31:0] entries [256];
  bit                 written [256];
  lookup_t            lookups [$];
  int                 errors;

  // returns 1 if the walk touches an entry never written
  function bit walk_search(logic signed [31:0] key, int lo, int hi, output lookup_t res);
    int mid;
    bit blind;
    blind = 0;
    res = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!written[mid]) blind = 1;
      if (key < entries[mid]) begin
        hi = mid - 1;
      end else if (key > entries[mid]) begin
        lo = mid + 1;
      end else begin
        res.found = 1'b1;
        res.position = mid[7:0];
        break;
      end
    end
    return blind;
  endfunction

  function void note_transfer(logic act, logic [bst_pkg::IN_TDATA_W-1:0] data);
    lookup_t res;
    if (act == bst_pkg::ACT_WRITE) begin
      entries[data[7:0]] = data[39:8];
      written[data[7:0]] = 1'b1;
    end else begin
      void'(walk_search(data[71:40], data[79:72], data[87:80], res));
      lookups.push_back(res);
    end
  endfunction

  function void check_result(logic [bst_pkg::OUT_TDATA_W-1:0] data);
    lookup_t want;
    if (lookups.size() == 0) begin
      $display("%0t: result with nothing outstanding, found %0d position %0d",
               $time, data[0], data[8:1]);
      errors++;
      return;
    end
    want = lookups.pop_front();
    if (data[0] !== want.found) begin
      $display("%0t: found expected %0d actual %0d", $time, want.found, data[0]);
      errors++;
    end
    if (data[8:1] !== want.position) begin
      $display("%0t: position expected %0d actual %0d", $time, want.position, data[8:1]);
      errors++;
    end
  endfunction

  function int pending();
    return lookups.size();
  endfunction
endclass

module binary_search_table_tb;

  localparam int ITEM_COUNT  = 2000;
  localparam int HOLD_AT     = 700;
  localparam int PAUSE_AT    = 1200;
  localparam int QUIET_AT    = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [bst_pkg::IN_TDATA_W-1:0]     in_tdata;
  logic                               in_tuser;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [bst_pkg::OUT_TDATA_W-1:0]    out_tdata;

  table_tracker tracker;
  int           n_sent;
  int           cycles;
  bit           hold_req;
  bit           hold_done;

  binary_search_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("binary_search_table_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  // result side: random stall bursts, one long hold-off, none near the end
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1;
      end else if (n_sent < QUIET_AT && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic act, input logic [bst_pkg::IN_TDATA_W-1:0] data);
    @(negedge clk);
    if (n_sent < QUIET_AT && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    tracker.note_transfer(act, data);
    n_sent++;
  endtask

  task automatic write_item(input logic [7:0] idx, input logic signed [31:0] val);
    send_item(bst_pkg::ACT_WRITE, {8'($urandom), 8'($urandom), 32'($urandom), val, idx});
  endtask

  // searches that would read a never-written entry are dropped
  task automatic search_item(input logic signed [31:0] key, input logic [7:0] lo,
                             input logic [7:0] hi);
    lookup_t unused;
    if (tracker.walk_search(key, lo, hi, unused)) return;
    send_item(bst_pkg::ACT_SEARCH, {hi, lo, key, 32'($urandom), 8'($urandom)});
  endtask

  // ascending table; style 1 pins the value extremes at both ends
  task automatic fill_table(input int unsigned style);
    longint v;
    case (style)
      0:       v = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd1073741824;
      1:       v = longint'($urandom_range(0, 1 << 20)) - 64'sd2147483648;
      default: v = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd2147483648;
    endcase
    for (int i = 0; i < 256; i++) begin
      if (i > 0) begin
        case (style)
          0:       v += $urandom_range(0, 3);
          1:       v += $urandom_range(0, 1 << 24);
          default: v += $urandom_range(0, 1 << 22);
        endcase
      end
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (style == 1 && i == 0)        write_item(8'(i), VAL_MIN);
      else if (style == 1 && i == 255) write_item(8'(i), VAL_MAX);
      else                             write_item(8'(i), v[31:0]);
    end
  endtask

  task automatic random_write();
    logic [7:0] idx;
    longint     lower;
    longint     upper;
    idx = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      write_item(idx, 32'($urandom));
    end else begin
      // keep the table ordered around the rewritten entry
      lower = (idx == 0)   ? longint'(VAL_MIN) : longint'(tracker.entries[idx - 1]);
      upper = (idx == 255) ? longint'(VAL_MAX) : longint'(tracker.entries[idx + 1]);
      if (lower <= upper)
        write_item(idx, 32'(lower + longint'($urandom) % (upper - lower + 1)));
      else
        write_item(idx, tracker.entries[idx]);
    end
  endtask

  task automatic random_search();
    logic signed [31:0] key;
    logic [7:0]         lo;
    logic [7:0]         hi;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)      key = tracker.entries[$urandom_range(0, 255)];
    else if (pick < 7) key = tracker.entries[$urandom_range(0, 255)] +
                             ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
    else               key = 32'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      lo = 8'($urandom_range(0, 255));
      hi = 8'($urandom_range(lo, 255));
    end else if (pick == 7) begin
      lo = 8'd0;
      hi = 8'd255;
    end else if (pick == 8) begin
      lo = 8'($urandom_range(0, 255));
      hi = lo;
    end else begin
      lo = 8'($urandom_range(1, 255));
      hi = 8'($urandom_range(0, lo - 1));
    end
    search_item(key, lo, hi);
  endtask

  initial begin
    int unsigned choice;
    bit          paused;
    tracker    = new;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = bst_pkg::ACT_WRITE;
    in_tdata   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // small ascending table with duplicates and the top value
    write_item(8'd0, VAL_MIN + 32'sd1);
    write_item(8'd1, -32'sd1000);
    write_item(8'd2, -32'sd1);
    write_item(8'd3, 32'sd0);
    write_item(8'd4, 32'sd5);
    write_item(8'd5, 32'sd5);
    write_item(8'd6, 32'sd1000);
    write_item(8'd7, VAL_MAX);
    search_item(VAL_MIN, 8'd0, 8'd7);     // falls off below index zero
    search_item(VAL_MAX, 8'd0, 8'd7);
    search_item(32'sd0, 8'd0, 8'd7);
    search_item(32'sd5, 8'd0, 8'd7);
    search_item(32'sd6, 8'd0, 8'd7);
    search_item(-32'sd1, 8'd2, 8'd2);
    search_item(32'sd0, 8'd5, 8'd2);      // empty range
    search_item(32'sd0, 8'd255, 8'd0);
    write_item(8'd0, VAL_MIN);
    search_item(VAL_MIN, 8'd0, 8'd7);
    write_item(8'd255, VAL_MAX);
    search_item(VAL_MAX, 8'd255, 8'd255);
    write_item(8'd3, 32'sd999999);        // table no longer ordered
    search_item(32'sd1000, 8'd0, 8'd7);
    search_item(-32'sd1000, 8'd0, 8'd7);

    fill_table(1);
    paused = 0;
    while (n_sent < ITEM_COUNT) begin
      if (n_sent >= HOLD_AT) hold_req = 1;
      if (n_sent >= PAUSE_AT && !paused) begin
        paused = 1;
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      choice = $urandom_range(0, 299);
      if (choice == 0)      fill_table($urandom_range(0, 2));
      else if (choice < 46) random_write();
      else                  random_search();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("binary_search_table_tb passed");
    end else begin
      $display("binary_search_table_tb failed");
    end
    $finish;
  end

endmodule
